// File: sv/rcc_pkg.sv
`timescale 1ns / 1ps
package rcc_pkg;

  localparam int unsigned SqrtBits = 34;
  localparam int unsigned QuoBits  = 31;
  localparam logic [31:0] OneQ30   = 32'h4000_0000;

  typedef struct packed {
    logic             ok;
    logic [2:0]       neg;
    logic [2:0][32:0] mag;
  } geo_t;

  typedef struct packed {
    geo_t        g;
    logic [67:0] rem;
    logic [33:0] root;
  } sq_t;

  typedef struct packed {
    logic             contact;
    logic             is_long;
    logic [30:0]      pen;
    logic [33:0]      span;
    logic [2:0]       neg;
    logic [2:0]       nz;
    logic [2:0]       ovf;
    logic [2:0][62:0] rem;
    logic [2:0][30:0] quo;
  } dv_t;

endpackage

// File: sv/rod_constraint_contact_top.sv
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                                  | tuser
// s_axis  | in  | first_x/y/z, second_x/y/z (32 b each)              | first_present,
//         |     |                                                     | second_present, room_left
// m_axis  | out | normal_x/y/z (32 b each), penetration (31 b), pad 1 | contact_made
// cfg     | in  | rod_length (31 b)                                   | -
// one beat per cycle while the output is not stalled; stages: difference, square, sum, 34 root stages,
// compare, 31 divider stages, output register
// rst_ni clears all valid bits and sets rod_length to 1.0
// the whole pipeline holds while the output beat waits
module rod_constraint_contact_top
  import rcc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [30:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [191:0]  s_axis_tdata_i,  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [2:0]    s_axis_tuser_i,  // first_present, second_present, room_left
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [127:0]  m_axis_tdata_o,  // normal_x, normal_y, normal_z, penetration, pad
  output logic [0:0]    m_axis_tuser_o   // contact_made
);

  logic [30:0] rod_q;
  logic        en;
  logic        m_valid_q;

  assign en              = ~m_valid_q | m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rod_q <= 31'd65536;
    end else if (cfg_we_i) begin
      rod_q <= cfg_wdata_i;
    end
  end

  // stage 1: differences
  logic v1_q;
  geo_t g1_q, g1_d;

  always_comb begin
    logic signed [32:0] d;
    g1_d    = '0;
    g1_d.ok = &s_axis_tuser_i;
    for (int i = 0; i < 3; i++) begin
      d = $signed({s_axis_tdata_i[32*i+31], s_axis_tdata_i[32*i +: 32]})
        - $signed({s_axis_tdata_i[32*(i+3)+31], s_axis_tdata_i[32*(i+3) +: 32]});
      g1_d.neg[i] = d[32];
      g1_d.mag[i] = d[32] ? 33'(-d) : 33'(d);
    end
  end

  // stage 2: squares
  logic v2_q;
  geo_t g2_q;
  logic [2:0][65:0] sqr_q;

  // stage 3: sum
  logic v3_q;
  sq_t  s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q <= g1_d;
      g2_q <= g1_q;
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= 66'(g1_q.mag[i]) * 66'(g1_q.mag[i]);
      end
      s3_q.g    <= g2_q;
      s3_q.rem  <= 68'(sqr_q[0]) + 68'(sqr_q[1]) + 68'(sqr_q[2]);
      s3_q.root <= '0;
    end
  end

  // square root, one bit a stage
  logic [SqrtBits:0] sv_q;
  sq_t               sp_q [SqrtBits+1];

  assign sv_q[0] = v3_q;
  assign sp_q[0] = s3_q;

  for (genvar k = 0; k < SqrtBits; k++) begin : g_sqrt
    localparam int unsigned B = SqrtBits - 1 - k;
    sq_t         nx_d;
    logic [67:0] trial;

    always_comb begin
      trial = (68'(sp_q[k].root) << (B + 1)) | (68'd1 << (2 * B));
      nx_d  = sp_q[k];
      if (sp_q[k].rem >= trial) begin
        nx_d.rem     = sp_q[k].rem - trial;
        nx_d.root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sp_q[k+1] <= nx_d;
      end
    end
  end

  // compare with rod length, set up division
  logic dv0_q;
  dv_t  dp0_q, dp0_d;

  always_comb begin
    logic [33:0] span;
    logic [34:0] diff;
    span          = sp_q[SqrtBits].root;
    dp0_d         = '0;
    dp0_d.span    = span;
    dp0_d.contact = sp_q[SqrtBits].g.ok && (span != 34'(rod_q));
    dp0_d.is_long = span > 34'(rod_q);
    diff          = dp0_d.is_long ? 35'(span) - 35'(rod_q) : 35'(rod_q) - 35'(span);
    dp0_d.pen     = (diff > 35'h7FFF_FFFF) ? 31'h7FFF_FFFF : diff[30:0];
    dp0_d.neg     = sp_q[SqrtBits].g.neg;
    for (int i = 0; i < 3; i++) begin
      dp0_d.nz[i]  = (sp_q[SqrtBits].g.mag[i] != '0) && (span != '0);
      dp0_d.rem[i] = {sp_q[SqrtBits].g.mag[i], 30'd0};
      dp0_d.ovf[i] = 65'(dp0_d.rem[i]) >= {span, 31'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv0_q <= 1'b0;
    end else if (en) begin
      dv0_q <= sv_q[SqrtBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp0_q <= dp0_d;
    end
  end

  // restoring divider, one quotient bit a stage
  logic [QuoBits:0] dv_q;
  dv_t              dp_q [QuoBits+1];

  assign dv_q[0] = dv0_q;
  assign dp_q[0] = dp0_q;

  for (genvar k = 0; k < QuoBits; k++) begin : g_div
    localparam int unsigned B = QuoBits - 1 - k;
    dv_t         nx_d;
    logic [64:0] sub;

    always_comb begin
      sub  = 65'(dp_q[k].span) << B;
      nx_d = dp_q[k];
      for (int i = 0; i < 3; i++) begin
        if (65'(dp_q[k].rem[i]) >= sub) begin
          nx_d.rem[i]    = dp_q[k].rem[i] - sub[62:0];
          nx_d.quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else if (en) begin
        dv_q[k+1] <= dv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_q[k+1] <= nx_d;
      end
    end
  end

  // output register
  logic [127:0] tdata_d, tdata_q;
  logic         tuser_q;

  always_comb begin
    dv_t         f;
    logic [31:0] q;
    f       = dp_q[QuoBits];
    tdata_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (f.ovf[i] || (32'(f.quo[i]) > OneQ30)) begin
        q = OneQ30;
      end else begin
        q = 32'(f.quo[i]);
      end
      if (f.contact && f.nz[i]) begin
        tdata_d[32*i +: 32] = (f.neg[i] ^ f.is_long) ? -q : q;
      end
    end
    tdata_d[126:96] = f.contact ? f.pen : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_q[QuoBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
      tuser_q <= dp_q[QuoBits].contact;
    end
  end

  assign m_axis_tdata_o = tdata_q;
  assign m_axis_tuser_o = tuser_q;

endmodule
